// ===== sv/tile_map_row_blitter_top_assert.svh =====
// assertion macros for the tile map row blitter
// no dependencies; included by the top level
`ifndef TILE_MAP_ROW_BLITTER_TOP_ASSERT_SVH
`define TILE_MAP_ROW_BLITTER_TOP_ASSERT_SVH

// cond holds -> prop holds in the same cycle
`define TMRB_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("tmrb: same-cycle check failed");

// cond holds -> prop holds in the next cycle
`define TMRB_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("tmrb: next-cycle check failed");

`endif

// ===== sv/tmrb_pkg.sv =====
// shared types and constants of the tile map row blitter
// no dependencies; used by the interfaces, the top level and the testbench
package tmrb_pkg;

    // map store entries, a power of two
    localparam int MAP_DEPTH    = 4096;
    localparam int NUM_SEGMENTS = 14;
    localparam int MAP_WORD_W   = 16;

    // a segment is 64 by 64 entries
    localparam int SEG_COL_BITS = 6;
    localparam int SEG_ROW_BITS = 6;
    localparam int SEG_WIDTH    = 1 << SEG_COL_BITS;
    localparam int SEG_SHIFT    = SEG_COL_BITS + SEG_ROW_BITS;

    // flip bits sit at 13:12 of an entry
    localparam int FLIP_SHIFT   = 12;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int COLS_W       = 7;
    localparam int ROWS_W       = 8;
    localparam int IDX_BASE_W   = 15;

    localparam logic [ROWS_W-1:0] ROWS_DONE = 8'hFF;

    typedef enum logic [1:0] {
        OP_RESTART = 2'd0,
        OP_STEP    = 2'd1,
        OP_LOAD    = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_COLS       = 3'd0,
        CFG_MAP_ROWS       = 3'd1,
        CFG_DEST_X         = 3'd2,
        CFG_DEST_Y         = 3'd3,
        CFG_SEGMENT_INDEX  = 3'd4,
        CFG_FLIP_MODE      = 3'd5,
        CFG_ENTRY_OFFSET   = 3'd6,
        CFG_PAD_ROW_ENABLE = 3'd7
    } t_cfg_reg;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RUN  = 1'b1
    } t_state;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [11:0] map_index;
        logic [15:0] map_value;
    } t_in_word;

    typedef struct packed {
        logic [15:0] write_address;
        logic [15:0] write_data;
        logic        write_enable;
        logic        last_of_run;
        logic        texture_done;
    } t_out_word;

    // word in flight between the map read and the output register
    typedef struct packed {
        logic [15:0] addr;
        logic        we;
        logic        last;
        logic        done;
        logic        mem;
    } t_s1;

endpackage

// ===== sv/tmrb_if.sv =====
// valid/ready channel interfaces of the tile map row blitter
// depends on tmrb_pkg for the word types
interface tmrb_in_if;
    logic               valid;
    logic               ready;
    tmrb_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tmrb_out_if;
    logic                valid;
    logic                ready;
    tmrb_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/tmrb_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module tmrb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while not enabled
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tile_map_row_blitter_top.sv =====
// tile map row blitter: copies a loaded tile map into a 64-wide background
// segment one row per step word, bottom row first. Load words (opcode 2) go
// straight into the map ram; restart words (opcode 0) reload the row counter
// from map_rows. A step word (opcode 1) is accepted and sets up the row, then
// the single read port of the map ram hands out one entry per column, one a
// cycle while the read stage is free. Status-only steps (done, closing step
// without padding, zero columns) issue a single word. Results pass through a
// read stage and an output register, so the next word is accepted while the
// tail of a row is still draining. Map entries must be loaded before a row
// step reads them. MAP_DEPTH must be a power of two. The user must write
// configuration only while the block is idle; the block does not enforce it.
// depends on tmrb_pkg, tmrb_if, tmrb_ram and tile_map_row_blitter_top_assert.svh
`include "tile_map_row_blitter_top_assert.svh"

module tile_map_row_blitter_top #(
    parameter int MAP_DEPTH    = tmrb_pkg::MAP_DEPTH,
    parameter int NUM_SEGMENTS = tmrb_pkg::NUM_SEGMENTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tmrb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tmrb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tmrb_in_if.sink                         i_in,
    tmrb_out_if.source                      o_out
);

    // map ram address width, and the width of the index sum before wrapping
    localparam int AW = $clog2(MAP_DEPTH);
    localparam int IW = (AW > tmrb_pkg::IDX_BASE_W) ? AW : tmrb_pkg::IDX_BASE_W;
    localparam int CW = tmrb_pkg::COLS_W;
    localparam int RW = tmrb_pkg::ROWS_W;

    // configuration registers
    logic [CW-1:0] r_map_cols;
    logic [CW-1:0] r_map_rows;
    logic [5:0]    r_dest_x;
    logic [5:0]    r_dest_y;
    logic [3:0]    r_seg;
    logic [1:0]    r_flip;
    logic [15:0]   r_offset;
    logic          r_pad_en;

    // sequencer state
    tmrb_pkg::t_state r_state, n_state;
    logic [RW-1:0]    r_remaining, n_remaining;
    logic [CW-1:0]    r_left, n_left;
    logic [CW-1:0]    r_src_col, n_src_col;
    logic [CW-1:0]    r_dst_col, n_dst_col;
    logic             r_dst_dec, n_dst_dec;
    logic [tmrb_pkg::IDX_BASE_W-1:0] r_idx_base, n_idx_base;
    logic [15:0]      r_row_addr, n_row_addr;
    logic             r_run_mem, n_run_mem;
    logic             r_run_we, n_run_we;
    logic             r_run_done, n_run_done;

    // read stage and output register
    tmrb_pkg::t_s1       r_s1;
    logic                r_s1_valid;
    tmrb_pkg::t_out_word r_out;
    logic                r_out_valid;

    logic          w_accept;
    logic          w_issue;
    logic          w_load_out;
    logic          w_ram_we;
    logic [CW-1:0] w_cols;
    logic          w_seg_ok;
    logic [RW-1:0] w_rows_m1;
    logic [RW-1:0] w_src_row;
    logic [15:0]   w_seg_base;
    logic [IW-1:0] w_idx_sum;
    logic [15:0]   w_rdata;
    logic [15:0]   w_out_data;

    // -------------------------------------------------------------------
    // configuration port
    // -------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_cols <= CW'(1);
            r_map_rows <= CW'(1);
            r_dest_x   <= '0;
            r_dest_y   <= '0;
            r_seg      <= '0;
            r_flip     <= '0;
            r_offset   <= '0;
            r_pad_en   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tmrb_pkg::CFG_MAP_COLS:       r_map_cols <= i_cfg_data[CW-1:0];
                tmrb_pkg::CFG_MAP_ROWS:       r_map_rows <= i_cfg_data[CW-1:0];
                tmrb_pkg::CFG_DEST_X:         r_dest_x   <= i_cfg_data[5:0];
                tmrb_pkg::CFG_DEST_Y:         r_dest_y   <= i_cfg_data[5:0];
                tmrb_pkg::CFG_SEGMENT_INDEX:  r_seg      <= i_cfg_data[3:0];
                tmrb_pkg::CFG_FLIP_MODE:      r_flip     <= i_cfg_data[1:0];
                tmrb_pkg::CFG_ENTRY_OFFSET:   r_offset   <= i_cfg_data[15:0];
                tmrb_pkg::CFG_PAD_ROW_ENABLE: r_pad_en   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // -------------------------------------------------------------------
    // row setup terms, valid in the accept cycle
    // -------------------------------------------------------------------
    assign w_accept   = i_in.valid && i_in.ready;
    // wide maps are clipped to one segment row
    assign w_cols     = (r_map_cols > CW'(tmrb_pkg::SEG_WIDTH)) ?
                        CW'(tmrb_pkg::SEG_WIDTH) : r_map_cols;
    assign w_seg_ok   = {1'b0, r_seg} < 5'(NUM_SEGMENTS);
    assign w_rows_m1  = r_remaining - RW'(1);
    // vertical flip reads source rows top-down
    assign w_src_row  = r_flip[0] ? (RW'(r_map_rows) - w_rows_m1 - RW'(1)) : w_rows_m1;
    assign w_seg_base = 16'(r_seg) << tmrb_pkg::SEG_SHIFT;

    // -------------------------------------------------------------------
    // sequencer: setup on accept, then one column per issue
    // -------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmrb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_remaining = r_remaining;
        n_left      = r_left;
        n_src_col   = r_src_col;
        n_dst_col   = r_dst_col;
        n_dst_dec   = r_dst_dec;
        n_idx_base  = r_idx_base;
        n_row_addr  = r_row_addr;
        n_run_mem   = r_run_mem;
        n_run_we    = r_run_we;
        n_run_done  = r_run_done;
        w_ram_we    = 1'b0;
        case (r_state)
            tmrb_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (i_in.data.opcode)
                        tmrb_pkg::OP_LOAD: begin
                            w_ram_we = 1'b1;
                        end
                        tmrb_pkg::OP_RESTART: begin
                            n_remaining = RW'(r_map_rows);
                        end
                        tmrb_pkg::OP_STEP: begin
                            // default is a single status-only word
                            n_state    = tmrb_pkg::S_RUN;
                            n_left     = CW'(1);
                            n_src_col  = '0;
                            n_dst_col  = '0;
                            n_dst_dec  = 1'b0;
                            n_row_addr = '0;
                            n_run_mem  = 1'b0;
                            n_run_we   = 1'b0;
                            n_run_done = 1'b1;
                            if (r_remaining[RW-1]) begin
                                // already done: status only
                            end else if (r_remaining == '0) begin
                                // closing step, optional zero padding row
                                n_remaining = tmrb_pkg::ROWS_DONE;
                                if (r_pad_en && w_cols != '0) begin
                                    n_left     = w_cols;
                                    n_run_we   = w_seg_ok;
                                    n_row_addr = w_seg_base
                                               + ((16'(r_dest_y) + 16'(r_map_rows))
                                                  << tmrb_pkg::SEG_COL_BITS)
                                               + 16'(r_dest_x);
                                end
                            end else begin
                                n_remaining = w_rows_m1;
                                n_run_done  = 1'b0;
                                if (w_cols != '0) begin
                                    n_left     = w_cols;
                                    n_run_we   = w_seg_ok;
                                    n_run_mem  = 1'b1;
                                    n_row_addr = w_seg_base
                                               + ((16'(r_dest_y) + 16'(w_rows_m1))
                                                  << tmrb_pkg::SEG_COL_BITS)
                                               + 16'(r_dest_x);
                                    n_idx_base = tmrb_pkg::IDX_BASE_W'(
                                                 tmrb_pkg::IDX_BASE_W'(w_src_row)
                                                 * tmrb_pkg::IDX_BASE_W'(w_cols));
                                    // horizontal flip walks destination columns down
                                    n_dst_dec  = r_flip[1];
                                    n_dst_col  = r_flip[1] ? (w_cols - CW'(1)) : '0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tmrb_pkg::S_RUN: begin
                if (w_issue) begin
                    n_left    = r_left - CW'(1);
                    n_src_col = r_src_col + CW'(1);
                    n_dst_col = r_dst_dec ? (r_dst_col - CW'(1)) : (r_dst_col + CW'(1));
                    if (r_left == CW'(1)) begin
                        n_state = tmrb_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = tmrb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= tmrb_pkg::ROWS_DONE;
            r_left      <= '0;
        end else begin
            r_remaining <= n_remaining;
            r_left      <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src_col  <= n_src_col;
        r_dst_col  <= n_dst_col;
        r_dst_dec  <= n_dst_dec;
        r_idx_base <= n_idx_base;
        r_row_addr <= n_row_addr;
        r_run_mem  <= n_run_mem;
        r_run_we   <= n_run_we;
        r_run_done <= n_run_done;
    end

    assign i_in.ready = (r_state == tmrb_pkg::S_IDLE);

    // -------------------------------------------------------------------
    // map ram: loads write; while the read stage is free, row steps read one entry a cycle
    // -------------------------------------------------------------------
    // store index wraps at the map depth
    assign w_idx_sum = IW'(r_idx_base) + IW'(r_src_col);

    tmrb_ram #(
        .WIDTH (tmrb_pkg::MAP_WORD_W),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (AW'(i_in.data.map_index)),
        .i_wdata (i_in.data.map_value),
        .i_re    (w_issue && r_run_mem),
        .i_raddr (w_idx_sum[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // -------------------------------------------------------------------
    // read stage and output register
    // -------------------------------------------------------------------
    // a column is issued only when the read stage is free next cycle, so the
    // ram read data never has to be held elsewhere
    assign w_load_out = r_s1_valid && (!r_out_valid || o_out.ready);
    assign w_issue    = (r_state == tmrb_pkg::S_RUN) && (!r_s1_valid || w_load_out);

    // entry xor flip bits plus offset, wrapping at 16 bits
    assign w_out_data = r_s1.mem ?
                        ((w_rdata ^ (16'(r_flip) << tmrb_pkg::FLIP_SHIFT)) + r_offset) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_issue) begin
                r_s1_valid <= 1'b1;
            end else if (w_load_out) begin
                r_s1_valid <= 1'b0;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s1.addr <= r_row_addr + 16'(r_dst_col);
            r_s1.we   <= r_run_we;
            r_s1.last <= (r_left == CW'(1));
            r_s1.done <= r_run_done;
            r_s1.mem  <= r_run_mem;
        end
        if (w_load_out) begin
            r_out.write_address <= r_s1.addr;
            r_out.write_data    <= w_out_data;
            r_out.write_enable  <= r_s1.we;
            r_out.last_of_run   <= r_s1.last;
            r_out.texture_done  <= r_s1.done;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // -------------------------------------------------------------------
    // checks
    // -------------------------------------------------------------------
    // a run always has a column left to issue
    `TMRB_ASSERT_SAME(a_run_has_work, i_clk, i_rst_n, r_state == tmrb_pkg::S_RUN, r_left != '0)
    // words of the closing step and after never carry map data
    `TMRB_ASSERT_SAME(a_done_data_zero, i_clk, i_rst_n, o_out.valid && o_out.data.texture_done, o_out.data.write_data == '0)
    // the closing step marks the texture done
    `TMRB_ASSERT_NEXT(a_close_sets_done, i_clk, i_rst_n, w_accept && i_in.data.opcode == tmrb_pkg::OP_STEP && r_remaining == '0, r_remaining == tmrb_pkg::ROWS_DONE)

endmodule

// ===== test/tile_map_row_blitter_top_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the tile map row blitter: directed table, then random map phases
// depends on tmrb_pkg, tmrb_if and tile_map_row_blitter_top
module tile_map_row_blitter_top_test;
    import tmrb_pkg::*;

    // opcode 3 is accepted and ignored by the block
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES  = 100;   // longest row plus pipeline, with margin
    localparam int HOLD_CYCLES    = 400;   // long receiver stall, fills the block
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with nothing accepted
    localparam int ITEMS_TARGET   = 150;
    localparam int MIN_PHASES     = 7;

    // one full setting of the registers
    typedef struct packed {
        logic [6:0]  map_cols;
        logic [6:0]  map_rows;
        logic [5:0]  dest_x;
        logic [5:0]  dest_y;
        logic [3:0]  segment_index;
        logic [1:0]  flip_mode;
        logic [15:0] entry_offset;
        logic        pad_row_enable;
    } t_map_cfg;

    // a row of the directed table: a register write or an input word
    typedef struct {
        bit        is_cfg;
        t_cfg_reg  cfg_sel;
        logic [15:0] cfg_val;
        t_in_word  word;
        bit        typed;
        t_out_word typed_res;
    } t_plan_row;

    // per offered word: whether its single result is typed in by hand
    typedef struct {
        bit        typed;
        t_out_word res;
    } t_typed_check;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tmrb_in_if  in_ch ();
    tmrb_out_if out_ch ();

    tile_map_row_blitter_top uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_ch),
        .o_out     (out_ch)
    );

    // predictor state: registers, row counter and map store as the block holds them
    t_map_cfg    cur = '{map_cols: 7'd1, map_rows: 7'd1, default: '0};
    logic [7:0]  rows_left = ROWS_DONE;
    logic [15:0] map_mem [MAP_DEPTH];

    // stimulus side bookkeeping: which store entries have been loaded so far
    bit tile_loaded [MAP_DEPTH];

    t_out_word    pending_writes[$];   // expected result words, oldest first
    t_out_word    row_writes[$];       // results of the word just predicted
    t_typed_check typed_checks[$];     // one per offered word, in offer order
    t_plan_row    plan[$];

    int mismatches   = 0;
    int words_sent   = 0;
    int words_in     = 0;
    int words_out    = 0;
    int settings_cnt = 0;
    int quiet_cycles = 0;

    bit gaps_on     = 1'b1;   // random idling on both sides
    bit squeeze_req = 1'b0;   // asks the receiver for a long hold-off

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic t_out_word status_word(logic done);
        t_out_word o;
        o = '0;
        o.last_of_run  = 1'b1;
        o.texture_done = done;
        return o;
    endfunction

    // expected writes caused by one accepted word, left in row_writes
    function automatic void blit_word(t_in_word w);
        int unsigned cols, base, srow, col, r, c;
        logic [15:0] entry;
        logic        seg_ok;
        t_out_word   o;
        row_writes.delete();
        if (w.opcode == OP_LOAD) begin
            map_mem[w.map_index] = w.map_value;
            return;
        end
        if (w.opcode == OP_RESTART) begin
            rows_left = {1'b0, cur.map_rows};
            return;
        end
        if (w.opcode != OP_STEP)
            return;

        // column count clips at the segment width
        cols   = (cur.map_cols > SEG_WIDTH) ? SEG_WIDTH : cur.map_cols;
        seg_ok = int'(cur.segment_index) < NUM_SEGMENTS;
        base   = (int'(cur.segment_index) << SEG_SHIFT)
               + (int'(cur.dest_y) << SEG_COL_BITS) + int'(cur.dest_x);

        if (rows_left[7]) begin
            // already done: status only
            row_writes.push_back(status_word(1'b1));
        end else if (rows_left == 0) begin
            // closing step, optional zero row below the map
            rows_left = ROWS_DONE;
            if (cur.pad_row_enable && cols > 0) begin
                for (c = 0; c < cols; c++) begin
                    o = '0;
                    o.write_address = 16'(base + int'(cur.map_rows) * SEG_WIDTH + c);
                    o.write_enable  = seg_ok;
                    o.texture_done  = 1'b1;
                    row_writes.push_back(o);
                end
            end else begin
                row_writes.push_back(status_word(1'b1));
            end
        end else begin
            rows_left = rows_left - 8'd1;
            r = rows_left;
            // vertical flip walks the source rows in reverse
            srow = cur.flip_mode[0] ? ((int'(cur.map_rows) - r - 1) & 8'hFF) : r;
            for (c = 0; c < cols; c++) begin
                entry = map_mem[(srow * cols + c) % MAP_DEPTH];
                col   = cur.flip_mode[1] ? (cols - 1 - c) : c;
                o = '0;
                o.write_address = 16'(base + r * SEG_WIDTH + col);
                o.write_data    = (entry ^ ({14'd0, cur.flip_mode} << FLIP_SHIFT))
                                + cur.entry_offset;
                o.write_enable  = seg_ok;
                row_writes.push_back(o);
            end
            if (cols == 0)
                row_writes.push_back(status_word(1'b0));
        end
        row_writes[row_writes.size() - 1].last_of_run = 1'b1;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // monitor: register writes, accepted input words, accepted result words
    always @(posedge i_clk) begin
        t_typed_check tc;
        t_out_word    want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_MAP_COLS:       cur.map_cols       = i_cfg_data[6:0];
                    CFG_MAP_ROWS:       cur.map_rows       = i_cfg_data[6:0];
                    CFG_DEST_X:         cur.dest_x         = i_cfg_data[5:0];
                    CFG_DEST_Y:         cur.dest_y         = i_cfg_data[5:0];
                    CFG_SEGMENT_INDEX:  cur.segment_index  = i_cfg_data[3:0];
                    CFG_FLIP_MODE:      cur.flip_mode      = i_cfg_data[1:0];
                    CFG_ENTRY_OFFSET:   cur.entry_offset   = i_cfg_data;
                    CFG_PAD_ROW_ENABLE: cur.pad_row_enable = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                words_in++;
                tc = typed_checks.pop_front();
                blit_word(in_ch.data);
                // hand-typed rows replace the predicted word, state still advances
                if (tc.typed)
                    pending_writes.push_back(tc.res);
                else
                    foreach (row_writes[k]) pending_writes.push_back(row_writes[k]);
            end
            if (out_ch.valid && out_ch.ready) begin
                words_out++;
                if (pending_writes.size() == 0) begin
                    $error("result word with nothing expected: address 0x%0h data 0x%0h",
                           out_ch.data.write_address, out_ch.data.write_data);
                    mismatches++;
                end else begin
                    want = pending_writes.pop_front();
                    check_field("write_address", want.write_address,
                                out_ch.data.write_address);
                    check_field("write_data", want.write_data, out_ch.data.write_data);
                    check_field("write_enable", want.write_enable, out_ch.data.write_enable);
                    check_field("last_of_run", want.last_of_run, out_ch.data.last_of_run);
                    check_field("texture_done", want.texture_done, out_ch.data.texture_done);
                end
            end
        end
    end

    // watchdog: ends the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: %0d result words still expected", pending_writes.size());
                $display("tile_map_row_blitter_top verification failed");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                out_ch.ready <= !(gaps_on && $urandom_range(99) < 14);
            end
        end
    end

    // offer one word and hold it until accepted; valid stays high for a following word
    task automatic send_word(t_in_word w, bit typed, t_out_word typed_res);
        while (gaps_on && $urandom_range(99) < 14) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        typed_checks.push_back('{typed, typed_res});
        if (w.opcode == OP_LOAD)
            tile_loaded[w.map_index] = 1'b1;
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        if (w.opcode != OP_UNUSED)
            words_sent++;
    endtask

    task automatic send_op(logic [1:0] op, logic [11:0] idx, logic [15:0] val);
        t_in_word w;
        w.opcode    = op;
        w.map_index = idx;
        w.map_value = val;
        send_word(w, 1'b0, '0);
    endtask

    // wait for every expected word, then let loads and restarts settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_writes.size() != 0 || typed_checks.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg sel, logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= sel;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(t_map_cfg s);
        drain();
        write_reg(CFG_MAP_COLS, 16'(s.map_cols));
        write_reg(CFG_MAP_ROWS, 16'(s.map_rows));
        write_reg(CFG_DEST_X, 16'(s.dest_x));
        write_reg(CFG_DEST_Y, 16'(s.dest_y));
        write_reg(CFG_SEGMENT_INDEX, 16'(s.segment_index));
        write_reg(CFG_FLIP_MODE, 16'(s.flip_mode));
        write_reg(CFG_ENTRY_OFFSET, s.entry_offset);
        write_reg(CFG_PAD_ROW_ENABLE, 16'(s.pad_row_enable));
        settings_cnt++;
    endtask

    function automatic void add_cfg(t_cfg_reg sel, logic [15:0] val);
        t_plan_row row;
        row = '{cfg_sel: CFG_MAP_COLS, default: '0};
        row.is_cfg  = 1'b1;
        row.cfg_sel = sel;
        row.cfg_val = val;
        plan.push_back(row);
    endfunction

    function automatic void add_word(logic [1:0] op, logic [11:0] idx, logic [15:0] val);
        t_plan_row row;
        row = '{cfg_sel: CFG_MAP_COLS, default: '0};
        row.word.opcode    = op;
        row.word.map_index = idx;
        row.word.map_value = val;
        plan.push_back(row);
    endfunction

    function automatic void add_typed(logic [1:0] op, t_out_word res);
        t_plan_row row;
        row = '{cfg_sel: CFG_MAP_COLS, default: '0};
        row.word.opcode    = op;
        row.word.map_index = 12'($urandom);
        row.word.map_value = 16'($urandom);
        row.typed     = 1'b1;
        row.typed_res = res;
        plan.push_back(row);
    endfunction

    // mostly small maps, sometimes wide or tall ones, edges of the segment now and then
    function automatic t_map_cfg random_settings();
        t_map_cfg s;
        int unsigned pick;
        pick = $urandom_range(99);
        s.map_cols = (pick < 80) ? 7'($urandom_range(8, 1)) :
                     (pick < 95) ? 7'($urandom_range(64, 9)) : 7'($urandom_range(127, 65));
        pick = $urandom_range(99);
        s.map_rows = (pick < 85) ? 7'($urandom_range(6, 1)) :
                     (pick < 92) ? 7'd0 : 7'($urandom_range(12, 7));
        // keep the map area small: wide maps get one row, tall maps two columns at most
        if (s.map_cols > 7'd8 && s.map_rows > 7'd1)
            s.map_rows = 7'd1;
        if (s.map_rows > 7'd6 && s.map_cols > 7'd2)
            s.map_cols = 7'd2;
        pick = $urandom_range(99);
        s.dest_x = (pick < 15) ? 6'd63 : (pick < 30) ? 6'd0 : 6'($urandom);
        pick = $urandom_range(99);
        s.dest_y = (pick < 15) ? 6'd63 : (pick < 30) ? 6'd0 : 6'($urandom);
        s.segment_index = 4'($urandom_range(15));
        s.flip_mode     = 2'($urandom_range(3));
        pick = $urandom_range(99);
        s.entry_offset  = (pick < 15) ? 16'hFFFF : (pick < 25) ? 16'h0000 : 16'($urandom);
        s.pad_row_enable = 1'($urandom_range(1));
        return s;
    endfunction

    // one map: load what the rows will read, restart, step through all rows and close
    task automatic run_phase(t_map_cfg s, bit squeeze);
        int unsigned cols, area, steps, i, pick;
        bit restarted;
        apply_settings(s);
        cols = (s.map_cols > SEG_WIDTH) ? SEG_WIDTH : s.map_cols;
        area = s.map_rows * cols;
        // never read an entry that was not loaded; refresh some contents too
        for (i = 0; i < area; i++)
            if (!tile_loaded[i % MAP_DEPTH] || $urandom_range(99) < 25)
                send_op(OP_LOAD, 12'(i % MAP_DEPTH), 16'($urandom));
        repeat ($urandom_range(2))
            send_op(OP_LOAD, 12'($urandom), 16'($urandom));
        if (squeeze)
            squeeze_req = 1'b1;
        send_op(OP_RESTART, 12'($urandom), 16'($urandom));
        steps = s.map_rows + 1 + $urandom_range(2);
        restarted = 1'b0;
        for (i = 0; i < steps; i++) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                send_op(OP_UNUSED, 12'($urandom), 16'($urandom));
            end else if (pick < 11 && area > 0) begin
                // rewrite an entry of this map between row steps
                send_op(OP_LOAD, 12'($urandom_range(area - 1) % MAP_DEPTH), 16'($urandom));
            end else if (pick < 13 && !restarted) begin
                // restart in the middle of the map
                send_op(OP_RESTART, 12'($urandom), 16'($urandom));
                restarted = 1'b1;
                steps += s.map_rows;
            end
            send_op(OP_STEP, 12'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        t_map_cfg s;
        bit squeeze;
        bit cfg_quiet;
        int phase;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: reset state, 1x1 map, a flipped 2x2 map at the segment edge, then zero-column and empty maps
        add_typed(OP_STEP, status_word(1'b1));            // step right after reset
        add_word(OP_UNUSED, 12'hFFF, 16'hFFFF);
        add_word(OP_LOAD, 12'd0, 16'hFFFF);
        add_word(OP_LOAD, 12'hFFF, 16'h0000);
        add_word(OP_RESTART, 12'h000, 16'h0000);
        add_word(OP_STEP, 12'hFFF, 16'hFFFF);
        add_typed(OP_STEP, status_word(1'b1));            // closing step, no padding
        add_typed(OP_STEP, status_word(1'b1));            // step when done
        add_cfg(CFG_MAP_COLS, 16'd2);
        add_cfg(CFG_MAP_ROWS, 16'd2);
        add_cfg(CFG_DEST_X, 16'd63);
        add_cfg(CFG_DEST_Y, 16'd62);
        add_cfg(CFG_SEGMENT_INDEX, 16'd15);              // out of range, no real writes
        add_cfg(CFG_FLIP_MODE, 16'd3);
        add_cfg(CFG_ENTRY_OFFSET, 16'hC001);
        add_cfg(CFG_PAD_ROW_ENABLE, 16'd1);
        add_word(OP_LOAD, 12'd1, 16'h1234);
        add_word(OP_LOAD, 12'd2, 16'h3000);
        add_word(OP_LOAD, 12'd3, 16'hABCD);
        add_word(OP_RESTART, 12'd0, 16'd0);
        add_word(OP_STEP, 12'd0, 16'd0);
        add_word(OP_RESTART, 12'd0, 16'd0);               // reload rows mid-map
        add_word(OP_STEP, 12'd0, 16'd0);
        add_word(OP_STEP, 12'd0, 16'd0);
        add_word(OP_STEP, 12'd0, 16'd0);                  // padding row wraps the address
        add_cfg(CFG_MAP_COLS, 16'd0);
        add_cfg(CFG_MAP_ROWS, 16'd1);
        add_cfg(CFG_SEGMENT_INDEX, 16'd14);
        add_cfg(CFG_FLIP_MODE, 16'd0);
        add_cfg(CFG_ENTRY_OFFSET, 16'h0000);
        add_cfg(CFG_PAD_ROW_ENABLE, 16'd0);
        add_word(OP_RESTART, 12'd0, 16'd0);
        add_typed(OP_STEP, status_word(1'b0));            // zero columns
        add_typed(OP_STEP, status_word(1'b1));
        add_cfg(CFG_MAP_ROWS, 16'd0);
        add_cfg(CFG_MAP_COLS, 16'd3);
        add_cfg(CFG_PAD_ROW_ENABLE, 16'd1);
        add_word(OP_RESTART, 12'd0, 16'd0);
        add_word(OP_STEP, 12'd0, 16'd0);                  // empty map, padding only

        cfg_quiet = 1'b1;
        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                if (!cfg_quiet)
                    drain();
                cfg_quiet = 1'b1;
                write_reg(plan[i].cfg_sel, plan[i].cfg_val);
            end else begin
                cfg_quiet = 1'b0;
                send_word(plan[i].word, plan[i].typed, plan[i].typed_res);
            end
        end
        settings_cnt += 4;

        // random part: some phases forced to the register extremes
        for (phase = 0; phase < MIN_PHASES || words_sent < ITEMS_TARGET; phase++) begin
            s = random_settings();
            squeeze = 1'b0;
            case (phase)
                1: begin
                    // widest map, clipped to the segment; receiver holds off meanwhile
                    s.map_cols = 7'd127;
                    s.map_rows = 7'd1;
                    s.pad_row_enable = 1'b1;
                    squeeze = 1'b1;
                end
                2: begin
                    s.map_cols  = 7'd1;
                    s.map_rows  = 7'd12;
                    s.dest_y    = 6'd63;
                    s.flip_mode = 2'd1;
                end
                3: begin
                    s.map_cols = 7'd64;
                    s.map_rows = 7'd0;
                    s.pad_row_enable = 1'b1;
                end
                4: begin
                    s.map_cols = 7'd0;
                    s.map_rows = 7'd3;
                    s.pad_row_enable = 1'b1;
                end
                5: begin
                    s.map_cols = 7'd64;
                    s.map_rows = 7'd1;
                    s.segment_index = 4'd13;
                    s.dest_x = 6'd0;
                    s.dest_y = 6'd0;
                    s.flip_mode = 2'd2;
                    s.entry_offset = 16'hFFFF;
                end
                6: begin
                    s.segment_index = 4'd14;
                    s.dest_x = 6'd63;
                    s.dest_y = 6'd63;
                    s.flip_mode = 2'd3;
                    s.pad_row_enable = 1'b1;
                end
                default: ;
            endcase
            // a stretch of phases with no idling on either side
            gaps_on = !(phase >= 3 && phase <= 5);
            run_phase(s, squeeze);
        end

        gaps_on = 1'b1;
        drain();
        $display("covered %0d input words and %0d result words over %0d register settings",
                 words_in, words_out, settings_cnt);
        $display("including clipped, empty and padded maps, all flips and bad segments");
        if (mismatches == 0)
            $display("tile_map_row_blitter_top verification clean");
        else
            $display("tile_map_row_blitter_top verification failed");
        $finish;
    end

endmodule
